// ===== rtl/tsl_pkg.sv =====
// tsl_pkg: shared types and constants of the time sorted keyed list
`timescale 1ns / 1ps

package tsl_pkg;

  localparam int unsigned CapacityDefault = 16;
  localparam int unsigned HoursPerDay     = 24;
  localparam int unsigned MinutesPerHour  = 60;

  localparam int unsigned KeyWidth    = 64;
  localparam int unsigned HourWidth   = 5;
  localparam int unsigned MinuteWidth = 6;
  localparam int unsigned PosWidth    = 4;
  localparam int unsigned FillWidth   = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_CHANGE = 2'd2,
    ACT_LIST   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_DUP       = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_EMPTY     = 3'd4,
    STAT_LISTED    = 3'd5,
    STAT_BAD_TIME  = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DOWN,
    ST_UP,
    ST_WRITE,
    ST_LIST_RD,
    ST_LIST_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [KeyWidth-1:0]    key;
    logic [HourWidth-1:0]   hour;
    logic [MinuteWidth-1:0] minute;
  } entry_t;

endpackage

// ===== rtl/time_sorted_keyed_list.sv =====
// time_sorted_keyed_list: keyed entry list kept in ascending time order in one ram
// the scan, shift and list walks each go through the ram port
// one command at a time, taken again the cycle after its last result enters the
// output register; a result left waiting holds the next command at its emit step
// reset clears the entry count and the output valid flag; the ram needs no clearing
`timescale 1ns / 1ps

module time_sorted_keyed_list #(
  parameter int unsigned CAPACITY = tsl_pkg::CapacityDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // key [63:0], hour [68:64], minute [74:69], zeros
  input  logic [1:0]  s_axis_tuser,   // action [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // key, hour, minute, position, fill [83:79], zeros
  output logic [2:0]  m_axis_tuser,   // status [2:0]
  output logic        m_axis_tlast
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = $bits(tsl_pkg::entry_t);

  // command registers
  tsl_pkg::state_e  state_q, state_d;
  tsl_pkg::action_e act_q, act_d;
  logic [63:0]      key_q, key_d;
  logic [4:0]       hour_q, hour_d;
  logic [5:0]       minute_q, minute_d;

  // list state and walk pointers
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    ri_q, ri_d;       // read pointer of scan, shift and list walks
  logic             pend_q, pend_d;   // a read is in flight
  logic [CW-1:0]    pidx_q, pidx_d;   // index of the entry that the ram now shows; in the up walk, the slot it moves to
  logic             found_q, found_d;
  logic [AW-1:0]    fidx_q, fidx_d;
  tsl_pkg::entry_t  fent_q, fent_d;
  logic             ins_hit_q, ins_hit_d;
  logic [CW-1:0]    ins_pos_q, ins_pos_d;
  logic             phase2_q, phase2_d; // second scan of a change

  // pending single result
  tsl_pkg::status_e res_stat_q, res_stat_d;
  logic [63:0]      res_key_q, res_key_d;
  logic [4:0]       res_hour_q, res_hour_d;
  logic [5:0]       res_minute_q, res_minute_d;
  logic [CW-1:0]    res_pos_q, res_pos_d;

  // output register
  logic             out_valid_q, out_valid_d;
  tsl_pkg::status_e out_stat_q, out_stat_d;
  logic [63:0]      out_key_q, out_key_d;
  logic [4:0]       out_hour_q, out_hour_d;
  logic [5:0]       out_minute_q, out_minute_d;
  logic [3:0]       out_pos_q, out_pos_d;
  logic [4:0]       out_fill_q, out_fill_d;
  logic             out_last_q, out_last_d;

  // ram port
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  tsl_pkg::entry_t  ram_wdata, ram_rdata;
  logic [EW-1:0]    ram_rdata_raw;

  logic             in_accept, out_free, time_ok;
  logic             scan_done, down_done, up_done, full;
  logic             t_less;
  logic [15:0]      pos_wide, fill_wide;
  logic [CW-1:0]    pos_sel;
  tsl_pkg::action_e in_act;

  tsl_ram #(
    .Width (EW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = tsl_pkg::entry_t'(ram_rdata_raw);

  assign in_act        = tsl_pkg::action_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == tsl_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign time_ok       = (32'(s_axis_tdata[68:64]) < tsl_pkg::HoursPerDay) &&
                         (32'(s_axis_tdata[74:69]) < tsl_pkg::MinutesPerHour);

  // walk end conditions
  assign scan_done = (ri_q == count_q) && !pend_q;
  assign down_done = (ri_q >= count_q) && !pend_q;
  assign up_done   = (ri_q == ins_pos_q) && !pend_q;
  assign full      = (count_q == CW'(CAPACITY));

  // new time sorts strictly before the shown entry
  assign t_less = {hour_q, minute_q} < {ram_rdata.hour, ram_rdata.minute};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsl_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_act == tsl_pkg::ACT_LIST) begin
            state_d = (count_q == '0) ? tsl_pkg::ST_EMIT : tsl_pkg::ST_LIST_RD;
          end else if (in_act != tsl_pkg::ACT_DELETE && !time_ok) begin
            state_d = tsl_pkg::ST_EMIT;
          end else begin
            state_d = tsl_pkg::ST_SCAN;
          end
        end
      end
      tsl_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = phase2_q ? tsl_pkg::ST_UP : tsl_pkg::ST_DECIDE;
        end
      end
      tsl_pkg::ST_DECIDE: begin
        if (act_q == tsl_pkg::ACT_INSERT) begin
          state_d = (found_q || full) ? tsl_pkg::ST_EMIT : tsl_pkg::ST_UP;
        end else begin
          state_d = found_q ? tsl_pkg::ST_DOWN : tsl_pkg::ST_EMIT;
        end
      end
      tsl_pkg::ST_DOWN: begin
        if (down_done) begin
          state_d = (act_q == tsl_pkg::ACT_DELETE) ? tsl_pkg::ST_EMIT : tsl_pkg::ST_SCAN;
        end
      end
      tsl_pkg::ST_UP: begin
        if (up_done) begin
          state_d = tsl_pkg::ST_WRITE;
        end
      end
      tsl_pkg::ST_WRITE:    state_d = tsl_pkg::ST_EMIT;
      tsl_pkg::ST_LIST_RD:  state_d = tsl_pkg::ST_LIST_WAIT;
      tsl_pkg::ST_LIST_WAIT: begin
        if (out_free) begin
          state_d = (ri_q + CW'(1) == count_q) ? tsl_pkg::ST_IDLE : tsl_pkg::ST_LIST_RD;
        end
      end
      tsl_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = tsl_pkg::ST_IDLE;
        end
      end
      default: state_d = tsl_pkg::ST_IDLE;
    endcase
  end

  // datapath, ram controls and output register
  always_comb begin
    act_d        = act_q;
    key_d        = key_q;
    hour_d       = hour_q;
    minute_d     = minute_q;
    count_d      = count_q;
    ri_d         = ri_q;
    pend_d       = pend_q;
    pidx_d       = pidx_q;
    found_d      = found_q;
    fidx_d       = fidx_q;
    fent_d       = fent_q;
    ins_hit_d    = ins_hit_q;
    ins_pos_d    = ins_pos_q;
    phase2_d     = phase2_q;
    res_stat_d   = res_stat_q;
    res_key_d    = res_key_q;
    res_hour_d   = res_hour_q;
    res_minute_d = res_minute_q;
    res_pos_d    = res_pos_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_stat_d   = out_stat_q;
    out_key_d    = out_key_q;
    out_hour_d   = out_hour_q;
    out_minute_d = out_minute_q;
    out_pos_d    = out_pos_q;
    out_fill_d   = out_fill_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = '0;
    ram_raddr    = '0;
    ram_wdata    = ram_rdata;
    pos_sel      = res_pos_q;

    case (state_q)
      tsl_pkg::ST_IDLE: begin
        if (in_accept) begin
          act_d     = in_act;
          key_d     = s_axis_tdata[63:0];
          hour_d    = s_axis_tdata[68:64];
          minute_d  = s_axis_tdata[74:69];
          ri_d      = '0;
          pend_d    = 1'b0;
          found_d   = 1'b0;
          ins_hit_d = 1'b0;
          ins_pos_d = count_q;
          phase2_d  = 1'b0;
          res_hour_d   = '0;
          res_minute_d = '0;
          res_pos_d    = '0;
          if (in_act == tsl_pkg::ACT_LIST) begin
            res_stat_d = tsl_pkg::STAT_EMPTY;
            res_key_d  = '0;
          end else begin
            res_stat_d = tsl_pkg::STAT_BAD_TIME;
            res_key_d  = s_axis_tdata[63:0];
          end
        end
      end

      // one read a cycle, each entry compared in the cycle after its read
      tsl_pkg::ST_SCAN: begin
        if (ri_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = ri_q[AW-1:0];
          ri_d      = ri_q + CW'(1);
          pend_d    = 1'b1;
          pidx_d    = ri_q;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (!found_q && ram_rdata.key == key_q) begin
            found_d = 1'b1;
            fidx_d  = pidx_q[AW-1:0];
            fent_d  = ram_rdata;
          end
          if (!ins_hit_q && t_less) begin
            ins_hit_d = 1'b1;
            ins_pos_d = pidx_q;
          end
        end
        if (scan_done) begin
          ri_d = count_q;
        end
      end

      tsl_pkg::ST_DECIDE: begin
        pend_d = 1'b0;
        if (act_q == tsl_pkg::ACT_INSERT) begin
          res_key_d = key_q;
          if (found_q) begin
            res_stat_d   = tsl_pkg::STAT_DUP;
            res_hour_d   = fent_q.hour;
            res_minute_d = fent_q.minute;
            res_pos_d    = CW'(fidx_q);
          end else if (full) begin
            res_stat_d   = tsl_pkg::STAT_FULL;
            res_hour_d   = hour_q;
            res_minute_d = minute_q;
            res_pos_d    = '0;
          end
          ri_d = count_q;
        end else begin
          res_key_d = key_q;
          if (!found_q) begin
            res_stat_d   = tsl_pkg::STAT_NOT_FOUND;
            res_hour_d   = '0;
            res_minute_d = '0;
            res_pos_d    = '0;
          end else begin
            // delete reports the removed entry where it stood
            res_stat_d   = tsl_pkg::STAT_OK;
            res_hour_d   = fent_q.hour;
            res_minute_d = fent_q.minute;
            res_pos_d    = CW'(fidx_q);
          end
          ri_d = CW'(fidx_q) + CW'(1);
        end
      end

      // close the gap: read entry j+1, write it to j in the next cycle
      tsl_pkg::ST_DOWN: begin
        if (ri_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = ri_q[AW-1:0];
          ri_d      = ri_q + CW'(1);
          pend_d    = 1'b1;
          pidx_d    = ri_q;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pidx_q - CW'(1));
          ram_wdata = ram_rdata;
        end
        if (down_done) begin
          count_d = count_q - CW'(1);
          if (act_q == tsl_pkg::ACT_CHANGE) begin
            phase2_d  = 1'b1;
            ri_d      = '0;
            ins_hit_d = 1'b0;
            ins_pos_d = count_q - CW'(1);
          end
        end
      end

      // open a slot: read entry j-1 going down, write it to j in the next cycle
      tsl_pkg::ST_UP: begin
        if (ri_q > ins_pos_q) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ri_q - CW'(1));
          ri_d      = ri_q - CW'(1);
          pend_d    = 1'b1;
          pidx_d    = ri_q;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q[AW-1:0];
          ram_wdata = ram_rdata;
        end
      end

      tsl_pkg::ST_WRITE: begin
        ram_we           = 1'b1;
        ram_waddr        = ins_pos_q[AW-1:0];
        ram_wdata.key    = key_q;
        ram_wdata.hour   = hour_q;
        ram_wdata.minute = minute_q;
        count_d          = count_q + CW'(1);
        res_stat_d       = tsl_pkg::STAT_OK;
        res_key_d        = key_q;
        res_hour_d       = hour_q;
        res_minute_d     = minute_q;
        res_pos_d        = ins_pos_q;
      end

      tsl_pkg::ST_LIST_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ri_q[AW-1:0];
      end

      tsl_pkg::ST_LIST_WAIT: begin
        pos_sel = ri_q;
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_stat_d   = tsl_pkg::STAT_LISTED;
          out_key_d    = ram_rdata.key;
          out_hour_d   = ram_rdata.hour;
          out_minute_d = ram_rdata.minute;
          out_pos_d    = pos_wide[3:0];
          out_fill_d   = fill_wide[4:0];
          out_last_d   = (ri_q + CW'(1) == count_q);
          ri_d         = ri_q + CW'(1);
        end
      end

      tsl_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_stat_d   = res_stat_q;
          out_key_d    = res_key_q;
          out_hour_d   = res_hour_q;
          out_minute_d = res_minute_q;
          out_pos_d    = pos_wide[3:0];
          out_fill_d   = fill_wide[4:0];
          out_last_d   = 1'b1;
        end
      end

      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  // position and fill go out in their low bits
  assign pos_wide  = 16'(pos_sel);
  assign fill_wide = 16'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsl_pkg::ST_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    key_q        <= key_d;
    hour_q       <= hour_d;
    minute_q     <= minute_d;
    ri_q         <= ri_d;
    pidx_q       <= pidx_d;
    found_q      <= found_d;
    fidx_q       <= fidx_d;
    fent_q       <= fent_d;
    ins_hit_q    <= ins_hit_d;
    ins_pos_q    <= ins_pos_d;
    phase2_q     <= phase2_d;
    res_stat_q   <= res_stat_d;
    res_key_q    <= res_key_d;
    res_hour_q   <= res_hour_d;
    res_minute_q <= res_minute_d;
    res_pos_q    <= res_pos_d;
    out_stat_q   <= out_stat_d;
    out_key_q    <= out_key_d;
    out_hour_q   <= out_hour_d;
    out_minute_q <= out_minute_d;
    out_pos_q    <= out_pos_d;
    out_fill_q   <= out_fill_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'b0000, out_fill_q, out_pos_q, out_minute_q, out_hour_q,
                          out_key_q};

endmodule

// ===== rtl/tsl_ram.sv =====
// tsl_ram: generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module tsl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tsl_checker.sv =====
// tsl_checker: port level checks of the time sorted keyed list, bound to the top level
`timescale 1ns / 1ps

module tsl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // an empty list reports nothing but the status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == tsl_pkg::STAT_EMPTY |->
      m_axis_tlast && m_axis_tdata[83:0] == '0)
    else $error("empty status carries data");

  // only list results can be other than the last one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != tsl_pkg::STAT_LISTED |-> m_axis_tlast)
    else $error("single result without last");

  // not found and bad time results report a zero time and position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tsl_pkg::STAT_NOT_FOUND ||
                      m_axis_tuser == tsl_pkg::STAT_BAD_TIME) |->
      m_axis_tdata[78:64] == '0)
    else $error("rejected command reports time or position");

endmodule

bind time_sorted_keyed_list tsl_checker u_tsl_checker (.*);
